@@ sv/bis_pkg.sv @@
`timescale 1ns / 1ps

package bis_pkg;

	localparam int MAX_SIDE    = 256;
	localparam int STORE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int SIDE_W  = 9;
	localparam int COORD_W = 8;
	localparam int FRAC_W  = 16;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 4;
	localparam int PIX_W   = CH_W * NUM_CH;
	localparam int STEP_W  = SIDE_W + FRAC_W;
	localparam int POS_W   = COORD_W + STEP_W;
	localparam int INT_W   = POS_W - FRAC_W;
	localparam int NUM_TAP = 4;
	localparam int DIV_CNT_W = $clog2(STEP_W);

	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_DST_W = 2'd2;
	localparam logic [1:0] REG_DST_H = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVX,
		ST_DIVX_W,
		ST_DIVY,
		ST_DIVY_W,
		ST_POS,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_CAP,
		ST_HBL,
		ST_VBL
	} state_t;

	typedef struct packed {
		logic       div_start;
		logic       div_sel_y;
		logic       ld_dx;
		logic       ld_dy;
		logic       req_cap;
		logic       mem_wr;
		logic       pos_en;
		logic       rd_en;
		logic [1:0] rd_slot;
		logic       shift_pix;
		logic       hbl_en;
		logic       vbl_en;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_stat_t;

	function automatic logic [SIDE_W-1:0] side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (32'(v) > 32'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [SIDE_W-1:0] r,
		input logic [SIDE_W-1:0] c);
		logic [31:0] a;
		a = 32'(r) * 32'(MAX_SIDE) + 32'(c);
		return a[ADDR_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] p,
		input logic [PIX_W-1:0] q, input logic [CH_W-1:0] f);
		logic [PIX_W-1:0]  res;
		logic [CH_W-1:0]   a;
		logic [CH_W-1:0]   b;
		logic [2*CH_W-1:0] diff;
		logic [2*CH_W-1:0] prod;
		res = '0;
		for (int i = 0; i < NUM_CH; i++) begin
			a    = p[i*CH_W +: CH_W];
			b    = q[i*CH_W +: CH_W];
			diff = {{CH_W{1'b0}}, b} - {{CH_W{1'b0}}, a};
			prod = diff * {{CH_W{1'b0}}, f};
			res[i*CH_W +: CH_W] = a + prod[2*CH_W-1:CH_W];
		end
		return res;
	endfunction

endpackage

@@ sv/bis_div.sv @@
`timescale 1ns / 1ps

module bis_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bis_pkg::SIDE_W-1:0]   num_hi,
	input  logic [bis_pkg::SIDE_W-1:0]   den,
	output logic                         done,
	output logic [bis_pkg::STEP_W-1:0]   quot
);
	import bis_pkg::*;

	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [STEP_W-1:0]    acc_q;
	logic [SIDE_W-1:0]    rem_q;
	logic [SIDE_W-1:0]    den_q;

	logic [SIDE_W:0]   rem_sh;
	logic              ge;
	logic [SIDE_W:0]   rem_sub;
	logic [SIDE_W-1:0] rem_nx;

	always_comb begin
		rem_sh  = {rem_q, acc_q[STEP_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		rem_nx  = ge ? rem_sub[SIDE_W-1:0] : rem_sh[SIDE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && !start && (cnt_q == DIV_CNT_W'(STEP_W - 1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == DIV_CNT_W'(STEP_W - 1)) begin
					run_q <= 1'b0;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= {num_hi, {FRAC_W{1'b0}}};
			rem_q <= '0;
			den_q <= den;
		end else if (run_q) begin
			acc_q <= {acc_q[STEP_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign done = done_q;
	assign quot = acc_q;

endmodule

@@ sv/bis_ctrl.sv @@
`timescale 1ns / 1ps

module bis_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cmd,
	input  logic               cfg_wr,
	input  bis_pkg::dp_stat_t  stat,
	output logic               busy,
	output bis_pkg::dp_cmd_t   ctl
);
	import bis_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   redo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			redo_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				redo_q <= 1'b1;
			end else if (state_q == ST_DIVX) begin
				redo_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (redo_q) begin
					state_d = ST_DIVX;
				end else if (start) begin
					if (cmd == CMD_WRITE) begin
						ctl.mem_wr = 1'b1;
					end else begin
						ctl.req_cap = 1'b1;
						state_d     = ST_POS;
					end
				end
			end
			ST_DIVX: begin
				ctl.div_start = 1'b1;
				state_d       = ST_DIVX_W;
			end
			ST_DIVX_W: begin
				if (stat.div_done) begin
					ctl.ld_dx = 1'b1;
					state_d   = ST_DIVY;
				end
			end
			ST_DIVY: begin
				ctl.div_start = 1'b1;
				ctl.div_sel_y = 1'b1;
				state_d       = ST_DIVY_W;
			end
			ST_DIVY_W: begin
				ctl.div_sel_y = 1'b1;
				if (stat.div_done) begin
					ctl.ld_dy = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_POS: begin
				ctl.pos_en = 1'b1;
				state_d    = ST_RD0;
			end
			ST_RD0: begin
				ctl.rd_en   = 1'b1;
				ctl.rd_slot = 2'd0;
				state_d     = ST_RD1;
			end
			ST_RD1: begin
				ctl.rd_en     = 1'b1;
				ctl.rd_slot   = 2'd1;
				ctl.shift_pix = 1'b1;
				state_d       = ST_RD2;
			end
			ST_RD2: begin
				ctl.rd_en     = 1'b1;
				ctl.rd_slot   = 2'd2;
				ctl.shift_pix = 1'b1;
				state_d       = ST_RD3;
			end
			ST_RD3: begin
				ctl.rd_en     = 1'b1;
				ctl.rd_slot   = 2'd3;
				ctl.shift_pix = 1'b1;
				state_d       = ST_CAP;
			end
			ST_CAP: begin
				ctl.shift_pix = 1'b1;
				state_d       = ST_HBL;
			end
			ST_HBL: begin
				ctl.hbl_en = 1'b1;
				state_d    = ST_VBL;
			end
			ST_VBL: begin
				ctl.vbl_en = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE) || redo_q;

endmodule

@@ sv/bis_dp.sv @@
`timescale 1ns / 1ps

module bis_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bis_pkg::dp_cmd_t              ctl,
	output bis_pkg::dp_stat_t             stat,
	input  logic [bis_pkg::COORD_W-1:0]   col,
	input  logic [bis_pkg::COORD_W-1:0]   row,
	input  logic [bis_pkg::PIX_W-1:0]     pixel_in,
	input  logic [bis_pkg::SIDE_W-1:0]    src_width,
	input  logic [bis_pkg::SIDE_W-1:0]    src_height,
	input  logic [bis_pkg::SIDE_W-1:0]    dst_width,
	input  logic [bis_pkg::SIDE_W-1:0]    dst_height,
	output logic                          done,
	output logic [bis_pkg::PIX_W-1:0]     pixel_out
);
	import bis_pkg::*;

	logic [SIDE_W-1:0] sw;
	logic [SIDE_W-1:0] sh;
	logic [SIDE_W-1:0] dw;
	logic [SIDE_W-1:0] dh;
	logic [SIDE_W-1:0] sw_m1;
	logic [SIDE_W-1:0] sh_m1;
	logic [SIDE_W-1:0] dw_m1;
	logic [SIDE_W-1:0] dh_m1;

	logic              div_done;
	logic [STEP_W-1:0] div_quot;
	logic [SIDE_W-1:0] div_num;
	logic [SIDE_W-1:0] div_den;

	logic [STEP_W-1:0]  dx_q;
	logic [STEP_W-1:0]  dy_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [POS_W-1:0]   px_q;
	logic [POS_W-1:0]   py_q;
	logic               last_q;

	logic [COORD_W-1:0] row_c;
	logic               last_col;

	logic [INT_W-1:0]  x_int;
	logic [INT_W-1:0]  y_int;
	logic [SIDE_W-1:0] x0;
	logic [SIDE_W-1:0] x1;
	logic [SIDE_W-1:0] y0;
	logic [SIDE_W-1:0] y1;
	logic [SIDE_W-1:0] rd_r;
	logic [SIDE_W-1:0] rd_c;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic [ADDR_W-1:0] addr;

	logic [PIX_W-1:0] store_q [STORE_DEPTH];
	logic [PIX_W-1:0] rdata_q;
	logic [PIX_W-1:0] pix_q [NUM_TAP];
	logic [PIX_W-1:0] top_q;
	logic [PIX_W-1:0] bot_q;
	logic [PIX_W-1:0] out_q;
	logic             done_q;

	assign sw    = side(src_width);
	assign sh    = side(src_height);
	assign dw    = side(dst_width);
	assign dh    = side(dst_height);
	assign sw_m1 = sw - 1'b1;
	assign sh_m1 = sh - 1'b1;
	assign dw_m1 = dw - 1'b1;
	assign dh_m1 = dh - 1'b1;

	assign div_num = ctl.div_sel_y ? sh : sw;
	assign div_den = ctl.div_sel_y ? dh : dw;

	bis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num_hi (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign stat.div_done = div_done;

	always_comb begin
		if (SIDE_W'(row_q) > dh_m1) begin
			row_c = dh_m1[COORD_W-1:0];
		end else begin
			row_c = row_q;
		end
		last_col = SIDE_W'(col_q) >= dw_m1;
	end

	// source neighbors, clamped to the last row and column
	always_comb begin
		x_int = px_q[POS_W-1:FRAC_W];
		y_int = py_q[POS_W-1:FRAC_W];
		if (y_int > INT_W'(sh_m1)) begin
			y0 = sh_m1;
		end else begin
			y0 = y_int[SIDE_W-1:0];
		end
		y1 = (y0 == sh_m1) ? y0 : y0 + 1'b1;
		if (last_q || (x_int > INT_W'(sw_m1))) begin
			x0 = sw_m1;
		end else begin
			x0 = x_int[SIDE_W-1:0];
		end
		x1 = (x0 == sw_m1) ? x0 : x0 + 1'b1;
		rd_r  = ctl.rd_slot[1] ? y1 : y0;
		rd_c  = ctl.rd_slot[0] ? x1 : x0;
		raddr = cell_addr(rd_r, rd_c);
		waddr = cell_addr(SIDE_W'(row), SIDE_W'(col));
		addr  = ctl.mem_wr ? waddr : raddr;
	end

	always_ff @(posedge clk) begin
		if (ctl.mem_wr) begin
			store_q[addr] <= pixel_in;
		end
		if (ctl.rd_en) begin
			rdata_q <= store_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_dx) begin
			dx_q <= div_quot;
		end
		if (ctl.ld_dy) begin
			dy_q <= div_quot;
		end
		if (ctl.req_cap) begin
			col_q <= col;
			row_q <= row;
		end
		if (ctl.pos_en) begin
			px_q   <= {{STEP_W{1'b0}}, col_q} * {{COORD_W{1'b0}}, dx_q};
			py_q   <= {{STEP_W{1'b0}}, row_c} * {{COORD_W{1'b0}}, dy_q};
			last_q <= last_col;
		end
		if (ctl.shift_pix) begin
			for (int i = NUM_TAP - 1; i > 0; i--) begin
				pix_q[i] <= pix_q[i-1];
			end
			pix_q[0] <= rdata_q;
		end
		if (ctl.hbl_en) begin
			top_q <= mix(pix_q[3], pix_q[2], px_q[FRAC_W-1:FRAC_W-CH_W]);
			bot_q <= mix(pix_q[1], pix_q[0], px_q[FRAC_W-1:FRAC_W-CH_W]);
		end
		if (ctl.vbl_en) begin
			out_q <= mix(top_q, bot_q, py_q[FRAC_W-1:FRAC_W-CH_W]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.vbl_en;
		end
	end

	assign done      = done_q;
	assign pixel_out = out_q;

endmodule

@@ sv/bilinear_image_scaler_top.sv @@
`timescale 1ns / 1ps

// channel   ports                                   handshake
// request   start busy cmd col row pixel_in         taken when start && !busy
// result    done pixel_out                          one-cycle strobe on done
// config    psel penable pwrite paddr pwdata prdata write on access phase, pready high
//
// a write request goes straight into the frame store; the next request may follow at once
// a read request runs position multiply, four single-port frame store reads, a last tap
// shift, horizontal blend and vertical blend in turn; busy drops as done rises
// after reset and after every register write busy stays high
// while the shared 25-step divider recomputes both scale steps
// results cannot be held off: done is high for exactly one cycle

module bilinear_image_scaler_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          cmd,
	input  logic [bis_pkg::COORD_W-1:0]   col,
	input  logic [bis_pkg::COORD_W-1:0]   row,
	input  logic [bis_pkg::PIX_W-1:0]     pixel_in,
	output logic                          done,
	output logic [bis_pkg::PIX_W-1:0]     pixel_out,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bis_pkg::CFG_AW-1:0]    paddr,
	input  logic [bis_pkg::CFG_DW-1:0]    pwdata,
	output logic [bis_pkg::CFG_DW-1:0]    prdata,
	output logic                          pready
);
	import bis_pkg::*;

	logic              cfg_wr;
	logic [1:0]        reg_idx;
	logic [SIDE_W-1:0] src_w_q;
	logic [SIDE_W-1:0] src_h_q;
	logic [SIDE_W-1:0] dst_w_q;
	logic [SIDE_W-1:0] dst_h_q;
	dp_cmd_t           ctl;
	dp_stat_t          stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[CFG_AW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SIDE_W'(MAX_SIDE);
			src_h_q <= SIDE_W'(MAX_SIDE);
			dst_w_q <= SIDE_W'(MAX_SIDE);
			dst_h_q <= SIDE_W'(MAX_SIDE);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SRC_W: src_w_q <= pwdata[SIDE_W-1:0];
				REG_SRC_H: src_h_q <= pwdata[SIDE_W-1:0];
				REG_DST_W: dst_w_q <= pwdata[SIDE_W-1:0];
				REG_DST_H: dst_h_q <= pwdata[SIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SRC_W: prdata = CFG_DW'(src_w_q);
			REG_SRC_H: prdata = CFG_DW'(src_h_q);
			REG_DST_W: prdata = CFG_DW'(dst_w_q);
			REG_DST_H: prdata = CFG_DW'(dst_h_q);
			default:   prdata = '0;
		endcase
	end

	bis_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.cfg_wr (cfg_wr),
		.stat   (stat),
		.busy   (busy),
		.ctl    (ctl)
	);

	bis_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.col        (col),
		.row        (row),
		.pixel_in   (pixel_in),
		.src_width  (src_w_q),
		.src_height (src_h_q),
		.dst_width  (dst_w_q),
		.dst_height (dst_h_q),
		.done       (done),
		.pixel_out  (pixel_out)
	);

endmodule
